FILE: design/stid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table package
// Item types, command and status codes shared by the sorted table modules.
// ----------------------------------------------------------------------------
package stid_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // A dump never emits more than this many items.
  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic [3:0]         position;
    logic               last;
    logic [4:0]         entry_count;
  } out_item_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: design/stid_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module stid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/stid_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared comparator
// Signed greater-than and equality of a stored entry against the operand.
// ----------------------------------------------------------------------------
module stid_cmp (
  input  logic signed [31:0] entry,
  input  logic signed [31:0] operand,
  output stid_pkg::cmp_res_t res
);
  import stid_pkg::*;

  always_comb begin
    res.gt = (entry > operand);
    res.eq = (entry == operand);
  end

endmodule

FILE: design/sorted_table_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table with insert, delete and dump
// Keeps up to DEPTH signed values in ascending order in a RAM.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds in_ready low until that item
// is finished. All work goes through one RAM read port, one write port and one
// shared comparator, one entry per cycle but for dump steps that wait on the
// output. An insert moves each larger entry up one slot, from the top down, and
// then writes the value; a delete scans up for a match and moves every entry
// above it down; a dump emits one item per stored entry. Rejected commands and
// unused codes go straight to a status result. Each result is registered, and
// any step that produces a result waits while the output register still holds
// an earlier result that out_ready has not taken. A finished result sits there,
// so a new item can be accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stid_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stid_pkg::out_item_t out_data
);
  import stid_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_CMP   = 3'd1;
  localparam logic [2:0] S_INS_PUT   = 3'd2;
  localparam logic [2:0] S_DEL_SCAN  = 3'd3;
  localparam logic [2:0] S_DEL_SHIFT = 3'd4;
  localparam logic [2:0] S_DUMP      = 3'd5;
  localparam logic [2:0] S_EMIT      = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [1:0]         st_r, st_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data, rd_data;
  cmp_res_t      cmp;

  logic              slot_free;
  logic [CW-1:0]     count_m1, idx_m1, idx_m2, idx_p1, idx_p2;
  logic [CW+3:0]     idx_ext;
  logic [CW+4:0]     idx_p1_ext;
  logic [CW+4:0]     count_ext;
  logic [4:0]        count5;
  logic              dump_last;

  stid_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  stid_cmp u_cmp (
    .entry  ($signed(rd_data)),
    .operand(val_r),
    .res    (cmp)
  );

  assign slot_free  = !out_valid_r || out_ready;
  assign count_m1   = count_r - CW'(1);
  assign idx_m1     = idx_r - CW'(1);
  assign idx_m2     = idx_r - CW'(2);
  assign idx_p1     = idx_r + CW'(1);
  assign idx_p2     = idx_r + CW'(2);
  assign idx_ext    = {4'd0, idx_r};
  assign idx_p1_ext = {5'd0, idx_p1};
  assign count_ext  = {5'd0, count_r};
  assign count5     = count_ext[4:0];
  // A dump ends at the last stored entry or at the result limit.
  assign dump_last  = (idx_p1 == count_r) || (idx_p1_ext == (CW + 5)'(MAX_RESULTS));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    val_nxt       = val_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_data       = rd_data;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_data.value;
          idx_nxt = '0;
          case (in_data.command)
            CMD_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_EMIT;
              end else if (count_r == '0) begin
                state_nxt = S_INS_PUT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = count_m1[AW-1:0];
                idx_nxt   = count_r;
                state_nxt = S_INS_CMP;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DEL_SCAN;
              end
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              st_nxt    = ST_OK;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_INS_CMP: begin
        wr_en = 1'b1;
        if (cmp.gt) begin
          // Larger entry moves up one slot; keep walking down.
          idx_nxt = idx_m1;
          if (idx_r == CW'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_m2[AW-1:0];
          end
        end else begin
          wr_data   = val_r;
          count_nxt = count_r + CW'(1);
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end
      end

      S_INS_PUT: begin
        wr_en     = 1'b1;
        wr_data   = val_r;
        count_nxt = count_r + CW'(1);
        st_nxt    = ST_OK;
        state_nxt = S_EMIT;
      end

      S_DEL_SCAN: begin
        if (idx_p1 == count_r) begin
          if (cmp.eq) begin
            count_nxt = count_m1;
            st_nxt    = ST_OK;
          end else begin
            st_nxt    = ST_NOTFOUND;
          end
          state_nxt = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[AW-1:0];
          if (cmp.eq) begin
            state_nxt = S_DEL_SHIFT;
          end else begin
            idx_nxt = idx_p1;
          end
        end
      end

      S_DEL_SHIFT: begin
        // The entry above the hole moves down into it.
        wr_en   = 1'b1;
        idx_nxt = idx_p1;
        if (idx_p2 == count_r) begin
          count_nxt = count_m1;
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[AW-1:0];
        end
      end

      S_DUMP: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.entry_value = $signed(rd_data);
          out_data_nxt.position    = idx_ext[3:0];
          out_data_nxt.last        = dump_last;
          out_data_nxt.entry_count = count5;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_p1[AW-1:0];
            idx_nxt = idx_p1;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = st_r;
          out_data_nxt.entry_value = '0;
          out_data_nxt.position    = '0;
          out_data_nxt.last        = 1'b1;
          out_data_nxt.entry_count = count5;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/stid_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table checker
// Port-level checks on busy handling and result consistency.
// ----------------------------------------------------------------------------
module stid_chk #(
  parameter int DEPTH = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input stid_pkg::out_item_t out_data
);
  import stid_pkg::*;

  logic [4:0] full_count;
  assign full_count = 5'(DEPTH);

  // No result is valid in the cycle after a reset cycle.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Every accepted item takes in_ready low in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an item was accepted");

  // A dropped insert reports a full table.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.entry_count == full_count))
    else $error("full status with a count other than the depth");

  // An empty report has nothing stored and ends the command.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY) |->
      (out_data.entry_count == 5'd0 && out_data.last))
    else $error("empty status with entries stored or not last");

  // Any non-ok status is a single, final result with no entry.
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.last && out_data.entry_value == 32'sd0 && out_data.position == 4'd0))
    else $error("error status with entry data or not last");

endmodule

bind sorted_table_insert_delete stid_chk #(
  .DEPTH(DEPTH)
) u_stid_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
